[rtl/sem_pkg.sv]
// sobel edge magnitude package: shared types, register indexes and constants
// no dependencies; used by every module of the block but sem_ram by scoped names
`timescale 1ns / 1ps

package sem_pkg;

    // pixel and configuration widths
    localparam int PIX_W      = 8;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 11;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_ROWS = 4'd1;

    // register reset values and clamp limits
    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 12'd480;
    localparam logic [CFG_DATA_W-1:0] DIM_MIN        = 12'd3;
    localparam logic [CFG_DATA_W-1:0] ROWS_MAX       = 12'd2048;

    // saturation limit of the magnitude
    localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified pixel on its way to the window
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic             border;
        logic             fill_done;
        logic             frame_last;
    } sem_item_t;

    // queue handshake status seen by the top level
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } sem_q_status_t;

endpackage

[rtl/sem_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sem_front.sv]
// front part: configuration registers, raster position counters, line stores
// and classification of each pixel; depends on sem_pkg and sem_ram
`timescale 1ns / 1ps

module sem_front #(
    parameter int MAX_LINE = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sem_pkg::PIX_W-1:0]       s_pixel,
    input  logic                            q_full,
    output logic                            q_push,
    output sem_pkg::sem_item_t              q_item
);

    localparam int ADDR_W = $clog2(MAX_LINE);
    localparam int FILL_W = $clog2(MAX_LINE + 2);
    localparam int WCMP_W = (FILL_W > sem_pkg::CFG_DATA_W) ? FILL_W : sem_pkg::CFG_DATA_W;

    logic [sem_pkg::CFG_DATA_W-1:0] line_width_reg;
    logic [sem_pkg::CFG_DATA_W-1:0] frame_rows_reg;
    logic [ADDR_W-1:0]              col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [FILL_W-1:0]              fill_reg, fill_next;

    logic                           f_valid_reg;
    logic [ADDR_W-1:0]              f_addr_reg;
    logic [sem_pkg::PIX_W-1:0]      f_pixel_reg;
    logic                           f_border_reg;
    logic                           f_fill_reg;
    logic                           f_last_reg;

    logic [WCMP_W-1:0]              lw_ext;
    logic [WCMP_W-1:0]              eff_w;
    logic [sem_pkg::CFG_DATA_W-1:0] eff_rows;
    logic [FILL_W-1:0]              w_plus1;
    logic                           col_wrap;
    logic                           row_wrap;
    logic                           s_acc;
    logic                           cfg_hit;
    logic [sem_pkg::PIX_W-1:0]      top_rdata;
    logic [sem_pkg::PIX_W-1:0]      mid_rdata;

    // clamp the registers to their usable ranges
    always_comb begin
        lw_ext = WCMP_W'(line_width_reg);
        if (lw_ext < WCMP_W'(sem_pkg::DIM_MIN)) begin
            eff_w = WCMP_W'(sem_pkg::DIM_MIN);
        end else if (lw_ext > WCMP_W'(MAX_LINE)) begin
            eff_w = WCMP_W'(MAX_LINE);
        end else begin
            eff_w = lw_ext;
        end
        if (frame_rows_reg < sem_pkg::DIM_MIN) begin
            eff_rows = sem_pkg::DIM_MIN;
        end else if (frame_rows_reg > sem_pkg::ROWS_MAX) begin
            eff_rows = sem_pkg::ROWS_MAX;
        end else begin
            eff_rows = frame_rows_reg;
        end
    end

    assign w_plus1  = FILL_W'(eff_w) + FILL_W'(1);
    assign col_wrap = (WCMP_W'(col_reg) == eff_w - WCMP_W'(1));
    assign row_wrap = ({1'b0, row_reg} == eff_rows - sem_pkg::CFG_DATA_W'(1));

    // handshake: the fetch stage frees when its transaction enters the queue
    assign q_push  = f_valid_reg && !q_full;
    assign s_ready = !f_valid_reg || q_push;
    assign s_acc   = s_valid && s_ready;
    assign cfg_hit = cfg_we && ((cfg_addr == sem_pkg::CFG_LINE_WIDTH) ||
                                (cfg_addr == sem_pkg::CFG_FRAME_ROWS));

    // next raster position and fill count
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        fill_next = fill_reg;
        if (s_acc) begin
            if (fill_reg < w_plus1) begin
                fill_next = fill_reg + FILL_W'(1);
            end
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + sem_pkg::ROW_W'(1);
            end else begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= sem_pkg::LINE_WIDTH_RST;
            frame_rows_reg <= sem_pkg::FRAME_ROWS_RST;
        end else if (cfg_we) begin
            if (cfg_addr == sem_pkg::CFG_LINE_WIDTH) begin
                line_width_reg <= cfg_wdata;
            end
            if (cfg_addr == sem_pkg::CFG_FRAME_ROWS) begin
                frame_rows_reg <= cfg_wdata;
            end
        end
    end

    // position counters, restarted by a register write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            col_reg  <= '0;
            row_reg  <= '0;
            fill_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            fill_reg <= fill_next;
        end
    end

    // fetch stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_acc) begin
            f_valid_reg <= 1'b1;
        end else if (q_push) begin
            f_valid_reg <= 1'b0;
        end
    end

    // fetch stage payload: the delayed pixel is on a border when the column
    // or row counter sits at zero or one
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            f_addr_reg   <= col_reg;
            f_pixel_reg  <= s_pixel;
            f_border_reg <= (col_reg <= ADDR_W'(1)) || (row_reg <= sem_pkg::ROW_W'(1));
            f_last_reg   <= (col_reg == '0) && (row_reg == sem_pkg::ROW_W'(1));
            f_fill_reg   <= (fill_next == w_plus1);
        end
    end

    // line stores: read at accept, rotate when the transaction enters the queue
    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (MAX_LINE)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (q_push),
        .waddr (f_addr_reg),
        .wdata (mid_rdata),
        .re    (s_acc),
        .raddr (col_reg),
        .rdata (top_rdata)
    );

    sem_ram #(
        .WIDTH (sem_pkg::PIX_W),
        .DEPTH (MAX_LINE)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (q_push),
        .waddr (f_addr_reg),
        .wdata (f_pixel_reg),
        .re    (s_acc),
        .raddr (col_reg),
        .rdata (mid_rdata)
    );

    // queue entry
    always_comb begin
        q_item.pixel      = f_pixel_reg;
        q_item.top        = top_rdata;
        q_item.mid        = mid_rdata;
        q_item.border     = f_border_reg;
        q_item.fill_done  = f_fill_reg;
        q_item.frame_last = f_last_reg;
    end

endmodule

[rtl/sem_queue.sv]
// short fifo of classified pixels between the front and the back part
// depends on sem_pkg
`timescale 1ns / 1ps

module sem_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sem_pkg::sem_item_t     push_item,
    input  logic                   pop,
    output sem_pkg::sem_item_t     head_item,
    output logic                   full,
    output logic                   empty,
    output sem_pkg::sem_q_status_t status
);

    localparam int PTR_W = $clog2(sem_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sem_pkg::QUEUE_DEPTH + 1);

    sem_pkg::sem_item_t entry_reg [sem_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(sem_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        status.push  = push;
        status.pop   = pop;
        status.full  = full;
        status.empty = empty;
    end

endmodule

[rtl/sem_back.sv]
// back part: 3x3 window, sobel gradients, magnitude and output register
// depends on sem_pkg
`timescale 1ns / 1ps

module sem_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sem_pkg::sem_item_t        q_item,
    input  logic                      q_empty,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [sem_pkg::PIX_W-1:0] m_edge_res,
    output logic                      m_out_valid,
    output logic                      m_frame_last
);

    localparam int G_W = sem_pkg::PIX_W + 3;

    logic [sem_pkg::PIX_W-1:0] win_reg [3][3];
    logic                      s1_valid_reg, s1_border_reg, s1_fill_reg, s1_last_reg;
    logic                      s2_valid_reg, s2_border_reg, s2_fill_reg, s2_last_reg;
    logic signed [G_W-1:0]     gx_reg, gy_reg;
    logic                      m_valid_reg;
    logic [sem_pkg::PIX_W-1:0] m_edge_reg;
    logic                      m_fill_reg, m_last_reg;

    logic                      adv_out, adv2, adv1;
    logic [G_W-1:0]            x_pos, x_neg, y_pos, y_neg;
    logic signed [G_W-1:0]     gx_next, gy_next;
    logic [G_W-2:0]            ax, ay;
    logic [G_W-1:0]            mag;
    logic [sem_pkg::PIX_W-1:0] edge_next;

    // stage advance chain from the output register back to the queue
    assign adv_out = !m_valid_reg || m_ready;
    assign adv2    = !s2_valid_reg || adv_out;
    assign adv1    = !s1_valid_reg || adv2;
    assign q_pop   = !q_empty && adv1;

    // window shifts left, the new column comes from the queue entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (q_pop) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= q_item.top;
            win_reg[1][2] <= q_item.mid;
            win_reg[2][2] <= q_item.pixel;
        end
    end

    // stage one flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv1) begin
            s1_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_border_reg <= q_item.border;
            s1_fill_reg   <= q_item.fill_done;
            s1_last_reg   <= q_item.frame_last;
        end
    end

    // gradients from the current window
    always_comb begin
        x_pos = G_W'(win_reg[0][2]) + (G_W'(win_reg[1][2]) << 1) + G_W'(win_reg[2][2]);
        x_neg = G_W'(win_reg[0][0]) + (G_W'(win_reg[1][0]) << 1) + G_W'(win_reg[2][0]);
        y_pos = G_W'(win_reg[0][0]) + (G_W'(win_reg[0][1]) << 1) + G_W'(win_reg[0][2]);
        y_neg = G_W'(win_reg[2][0]) + (G_W'(win_reg[2][1]) << 1) + G_W'(win_reg[2][2]);
        gx_next = signed'(x_pos) - signed'(x_neg);
        gy_next = signed'(y_pos) - signed'(y_neg);
    end

    // stage two: registered gradients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            gx_reg        <= gx_next;
            gy_reg        <= gy_next;
            s2_border_reg <= s1_border_reg;
            s2_fill_reg   <= s1_fill_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // absolute sum with saturation, border pixels give zero
    always_comb begin
        ax  = gx_reg[G_W-1] ? (G_W-1)'(-gx_reg) : gx_reg[G_W-2:0];
        ay  = gy_reg[G_W-1] ? (G_W-1)'(-gy_reg) : gy_reg[G_W-2:0];
        mag = G_W'(ax) + G_W'(ay);
        if (s2_border_reg) begin
            edge_next = '0;
        end else if (mag > G_W'(sem_pkg::SAT_MAX)) begin
            edge_next = sem_pkg::SAT_MAX;
        end else begin
            edge_next = mag[sem_pkg::PIX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            m_edge_reg <= edge_next;
            m_fill_reg <= s2_fill_reg;
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_edge_res   = m_edge_reg;
    assign m_out_valid  = m_fill_reg;
    assign m_frame_last = m_last_reg;

endmodule

[rtl/sobel_edge_magnitude_core.sv]
// top level of the streaming 3x3 sobel edge magnitude block
// depends on sem_pkg, sem_front, sem_queue and sem_back
`timescale 1ns / 1ps

// Streaming Sobel edge magnitude: 8-bit grayscale pixels enter in raster
// order on the s_ channel and each one gives exactly one result on the m_
// channel: |Gx|+|Gy| saturated at 255 for the pixel one line plus one pixel
// back, 0 on the frame border, with m_frame_last marking the last pixel of a
// frame and m_out_valid low until line_width + 1 pixels have arrived since
// reset or the last register write. The block takes one pixel per clock while
// m_ready does not stall it; a pixel passes the line store read cycle, the
// four-entry queue and three back stages (window, gradients, magnitude) on
// its way to the output. The line stores are block rams of MAX_LINE bytes
// with no clearing pass; configuration writes (line_width at index 0,
// frame_rows at index 1) belong to idle periods and restart the frame
// position.

module sobel_edge_magnitude_core #(
    parameter int MAX_LINE = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sem_pkg::PIX_W-1:0]       s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sem_pkg::PIX_W-1:0]       m_edge_res,
    output logic                            m_out_valid,
    output logic                            m_frame_last
);

    sem_pkg::sem_item_t     push_item;
    sem_pkg::sem_item_t     head_item;
    sem_pkg::sem_q_status_t q_status;
    logic                   q_push, q_pop, q_full, q_empty;

    // front: position tracking, line stores and classification
    sem_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decoupling queue
    sem_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty),
        .status    (q_status)
    );

    // back: window, gradients and output register
    sem_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_item       (head_item),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_res   (m_edge_res),
        .m_out_valid  (m_out_valid),
        .m_frame_last (m_frame_last)
    );

    // the front never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.push |-> !q_status.full)
        else $error("queue push while full");

    // the back never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.pop |-> !q_status.empty)
        else $error("queue pop while empty");

    // the last pixel of a frame always comes after the window has filled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> m_out_valid)
        else $error("frame end flagged before fill");

endmodule
